// ===== rtl/core/sma_pkg.sv =====
// Package for the stack machine ALU: operation and error codes, sequencer
// states and default sizes. No dependencies.
`timescale 1ns / 1ps

package sma_pkg;

  // Default sizes, handed to the top level parameters
  localparam int STACK_DEPTH_DEF = 64;
  localparam int CELL_WIDTH_DEF  = 32;

  // Fixed payload widths of the channels
  localparam int FUNC_W  = 4;
  localparam int VALUE_W = 32;
  localparam int DEPTH_W = 7;
  localparam int ERR_W   = 2;

  // Value left by a division by zero
  localparam logic [15:0] DIV_ZERO_VAL = 16'hFFFF;

  typedef enum logic [FUNC_W-1:0] {
    F_PUSH   = 4'd0,
    F_ADD    = 4'd1,
    F_SUB    = 4'd2,
    F_MUL    = 4'd3,
    F_DIV    = 4'd4,
    F_DIVMOD = 4'd5,
    F_LT     = 4'd6,
    F_GT     = 4'd7,
    F_LE     = 4'd8,
    F_GE     = 4'd9,
    F_EQ     = 4'd10,
    F_AND    = 4'd11,
    F_OR     = 4'd12,
    F_INVERT = 4'd13,
    F_SHL    = 4'd14,
    F_SHR    = 4'd15
  } func_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK       = 2'd0,
    ERR_UNDERRUN = 2'd1,
    ERR_OVERFLOW = 2'd2
  } err_t;

  // Sequencer: idle, execute after stack read, wait on mul/div unit,
  // finish mul/div result, second write of /mod
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_MD,
    S_FIN,
    S_WR2
  } state_t;

endpackage

// ===== rtl/core/sma_if.sv =====
// Channel interfaces of the stack machine ALU: operation input and result output.
// Depends on sma_pkg.
`timescale 1ns / 1ps

interface sma_cmd_if;
  import sma_pkg::*;

  logic                valid;
  logic                ready;
  func_t               func;
  logic signed [VALUE_W-1:0] push_value;

  modport source (output valid, output func, output push_value, input ready);
  modport sink   (input valid, input func, input push_value, output ready);
endinterface

interface sma_rsp_if;
  import sma_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] top_cell;
  logic [DEPTH_W-1:0]        stack_depth;
  err_t                      error_code;

  modport source (output valid, output top_cell, output stack_depth, output error_code,
                  input ready);
  modport sink   (input valid, input top_cell, input stack_depth, input error_code,
                  output ready);
endinterface

// ===== rtl/core/sma_stack_mem.sv =====
// Cell store of the data stack: one write port, two synchronous read ports.
// Depends on nothing outside this file.
`timescale 1ns / 1ps

module sma_stack_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr_a,
  input  logic [AW-1:0]    rd_addr_b,
  output logic [WIDTH-1:0] rd_data_a,
  output logic [WIDTH-1:0] rd_data_b,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read ports, data held until next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

// ===== rtl/core/sma_muldiv.sv =====
// Iterative multiply and signed divide unit, one bit per cycle.
// Depends on nothing outside this file.
`timescale 1ns / 1ps

module sma_muldiv #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic         is_div,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic         done,
  output logic [W-1:0] result_q,
  output logic [W-1:0] result_r
);

  localparam int CW = $clog2(W + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic          div_op;
  logic          sa;
  logic          sb;
  logic [W-1:0]  acc;
  logic [W-1:0]  opnd;
  logic [W-1:0]  work;
  logic [W:0]    rem;
  logic [W:0]    trial;

  // restoring division trial subtract
  assign trial = {rem[W-1:0], work[W-1]} - {1'b0, opnd};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      div_op <= is_div;
      sa     <= a[W-1];
      sb     <= b[W-1];
      acc    <= '0;
      rem    <= '0;
      if (is_div) begin
        work <= a[W-1] ? (~a + 1'b1) : a;
        opnd <= b[W-1] ? (~b + 1'b1) : b;
      end else begin
        work <= b;
        opnd <= a;
      end
    end else if (busy) begin
      if (div_op) begin
        if (!trial[W]) begin
          rem  <= trial;
          work <= {work[W-2:0], 1'b1};
        end else begin
          rem  <= {rem[W-1:0], work[W-1]};
          work <= {work[W-2:0], 1'b0};
        end
      end else begin
        if (work[0]) begin
          acc <= acc + opnd;
        end
        opnd <= {opnd[W-2:0], 1'b0};
        work <= {1'b0, work[W-1:1]};
      end
    end
  end

  // sign correction: quotient truncates toward zero, remainder follows dividend
  assign result_q = div_op ? ((sa ^ sb) ? (~work + 1'b1) : work) : acc;
  assign result_r = sa ? (~rem[W-1:0] + 1'b1) : rem[W-1:0];

endmodule

// ===== rtl/core/stack_machine_alu.sv =====
// Top level of the stack machine ALU: sequencer, ALU and output register.
// Depends on sma_pkg, sma_if, sma_stack_mem and sma_muldiv.
//
// Usage:
//   cmd carries one operation per transfer (func, push_value); rsp returns
//   exactly one result per operation: the top cell after it (zero when the
//   stack is empty), the stack depth and an error code.
//   Operations are taken one at a time, in S_IDLE. A transfer on cmd reads
//   the top two cells of the stack memory into registers; in S_EXEC the
//   ALU then computes and writes back once the output register is free,
//   and the result is loaded into it. The next operation is taken when the
//   sequencer is back in S_IDLE. Multiply, divide and /mod (nonzero divisor,
//   two cells on the stack) go through the bit-serial mul/div unit (S_MD,
//   then S_FIN), and /mod does its second write-back in S_WR2.
//   The result sits in an output register; cmd stays open while it waits,
//   and the sequencer holds the next finished operation until rsp is free.
//   Reset empties the stack (depth zero) and clears the output valid flag;
//   cell contents are not cleared, cells are only read after being pushed.
`timescale 1ns / 1ps

module stack_machine_alu #(
  parameter int STACK_DEPTH = sma_pkg::STACK_DEPTH_DEF,
  parameter int CELL_WIDTH  = sma_pkg::CELL_WIDTH_DEF
) (
  input logic       clk,
  input logic       rst,
  sma_cmd_if.sink   cmd,
  sma_rsp_if.source rsp
);
  import sma_pkg::*;

  localparam int AW  = $clog2(STACK_DEPTH);
  localparam int DW  = $clog2(STACK_DEPTH + 1);
  localparam int SHW = $clog2(CELL_WIDTH);

  state_t                state;
  state_t                state_next;
  func_t                 func_r;
  logic [CELL_WIDTH-1:0] pv_r;
  logic [DW-1:0]         depth;
  logic [DW-1:0]         depth_next;

  logic [CELL_WIDTH-1:0] cell_a;
  logic [CELL_WIDTH-1:0] cell_b;
  logic [AW-1:0]         addr_a;
  logic [AW-1:0]         addr_b;
  logic                  accept;
  logic                  out_free;

  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [CELL_WIDTH-1:0] mem_wdata;

  logic                  md_start;
  logic                  md_is_div;
  logic                  md_done;
  logic [CELL_WIDTH-1:0] md_q;
  logic [CELL_WIDTH-1:0] md_r;

  logic                  needs_md;
  logic                  fin;
  logic [CELL_WIDTH-1:0] fin_top;
  err_t                  fin_err;
  logic [CELL_WIDTH-1:0] alu_r;
  logic [63:0]           pv_ext;
  logic [63:0]           top_ext;

  logic                      rsp_valid_r;
  logic signed [VALUE_W-1:0] rsp_top_r;
  logic [DEPTH_W-1:0]        rsp_depth_r;
  err_t                      rsp_err_r;

  assign accept   = cmd.valid && cmd.ready;
  assign out_free = !rsp_valid_r || rsp.ready;
  assign addr_b   = AW'(depth - 1'b1);
  assign addr_a   = AW'(depth - 2'd2);
  assign pv_ext   = 64'($signed(cmd.push_value));

  // operation capture
  always_ff @(posedge clk) begin
    if (accept) begin
      func_r <= cmd.func;
      pv_r   <= pv_ext[CELL_WIDTH-1:0];
    end
  end

  sma_stack_mem #(
    .DEPTH (STACK_DEPTH),
    .WIDTH (CELL_WIDTH)
  ) u_mem (
    .clk       (clk),
    .rd_en     (accept),
    .rd_addr_a (addr_a),
    .rd_addr_b (addr_b),
    .rd_data_a (cell_a),
    .rd_data_b (cell_b),
    .wr_en     (mem_we),
    .wr_addr   (mem_waddr),
    .wr_data   (mem_wdata)
  );

  sma_muldiv #(
    .W (CELL_WIDTH)
  ) u_muldiv (
    .clk      (clk),
    .rst      (rst),
    .start    (md_start),
    .is_div   (md_is_div),
    .a        (cell_a),
    .b        (cell_b),
    .done     (md_done),
    .result_q (md_q),
    .result_r (md_r)
  );

  // combinational ALU on A (below) and B (top)
  always_comb begin
    alu_r = '0;
    case (func_r)
      F_ADD:             alu_r = cell_a + cell_b;
      F_SUB:             alu_r = cell_a - cell_b;
      F_LT:              alu_r = CELL_WIDTH'($signed(cell_a) < $signed(cell_b));
      F_GT:              alu_r = CELL_WIDTH'($signed(cell_b) < $signed(cell_a));
      F_LE:              alu_r = CELL_WIDTH'(!($signed(cell_b) < $signed(cell_a)));
      F_GE:              alu_r = CELL_WIDTH'(!($signed(cell_a) < $signed(cell_b)));
      F_EQ:              alu_r = CELL_WIDTH'(cell_a == cell_b);
      F_AND:             alu_r = cell_a & cell_b;
      F_OR:              alu_r = cell_a | cell_b;
      F_SHL: begin
        if (cell_b >= CELL_WIDTH'(CELL_WIDTH)) alu_r = '0;
        else alu_r = cell_a << cell_b[SHW-1:0];
      end
      F_SHR: begin
        if (cell_b >= CELL_WIDTH'(CELL_WIDTH)) alu_r = {CELL_WIDTH{cell_a[CELL_WIDTH-1]}};
        else alu_r = $unsigned($signed(cell_a) >>> cell_b[SHW-1:0]);
      end
      F_DIV, F_DIVMOD:   alu_r = CELL_WIDTH'(DIV_ZERO_VAL);
      default:           alu_r = '0;
    endcase
  end

  assign needs_md  = (depth >= DW'(2)) &&
                     (func_r == F_MUL ||
                      ((func_r == F_DIV || func_r == F_DIVMOD) && cell_b != '0));
  assign md_is_div = (func_r != F_MUL);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept) state_next = S_EXEC;
      S_EXEC: begin
        if (needs_md) state_next = S_MD;
        else if (out_free) state_next = S_IDLE;
      end
      S_MD:   if (md_done) state_next = S_FIN;
      S_FIN: begin
        if (func_r == F_DIVMOD) state_next = S_WR2;
        else if (out_free) state_next = S_IDLE;
      end
      S_WR2:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // sequencer outputs: write-back, completion and result
  always_comb begin
    cmd.ready  = (state == S_IDLE);
    md_start   = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = addr_a;
    mem_wdata  = alu_r;
    fin        = 1'b0;
    fin_top    = '0;
    fin_err    = ERR_OK;
    depth_next = depth;
    unique case (state)
      S_IDLE: ;
      S_EXEC: begin
        if (needs_md) begin
          md_start = 1'b1;
        end else if (out_free) begin
          fin = 1'b1;
          if (func_r == F_PUSH) begin
            if (depth == DW'(STACK_DEPTH)) begin
              fin_err = ERR_OVERFLOW;
              fin_top = cell_b;
            end else begin
              mem_we     = 1'b1;
              mem_waddr  = AW'(depth);
              mem_wdata  = pv_r;
              fin_top    = pv_r;
              depth_next = depth + 1'b1;
            end
          end else if (func_r == F_INVERT) begin
            if (depth == '0) begin
              fin_err = ERR_UNDERRUN;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = addr_b;
              mem_wdata = ~cell_b;
              fin_top   = ~cell_b;
            end
          end else if (depth < DW'(2)) begin
            fin_err = ERR_UNDERRUN;
            fin_top = (depth == '0) ? '0 : cell_b;
          end else begin
            mem_we = 1'b1;
            if (func_r == F_DIVMOD) begin
              // zero divisor: B (zero) stays on top
              fin_top = cell_b;
            end else begin
              fin_top    = alu_r;
              depth_next = depth - 1'b1;
            end
          end
        end
      end
      S_MD: ;
      S_FIN: begin
        if (func_r == F_DIVMOD) begin
          mem_we    = 1'b1;
          mem_wdata = md_r;
        end else if (out_free) begin
          mem_we     = 1'b1;
          mem_wdata  = md_q;
          fin        = 1'b1;
          fin_top    = md_q;
          depth_next = depth - 1'b1;
        end
      end
      S_WR2: begin
        if (out_free) begin
          mem_we    = 1'b1;
          mem_waddr = addr_b;
          mem_wdata = md_q;
          fin       = 1'b1;
          fin_top   = md_q;
        end
      end
      default: ;
    endcase
  end

  // state and depth registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      depth <= '0;
    end else begin
      state <= state_next;
      depth <= depth_next;
    end
  end

  // output register
  assign top_ext = 64'($signed(fin_top));

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid_r <= 1'b0;
    end else if (fin) begin
      rsp_valid_r <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      rsp_top_r   <= top_ext[VALUE_W-1:0];
      rsp_depth_r <= DEPTH_W'(depth_next);
      rsp_err_r   <= fin_err;
    end
  end

  assign rsp.valid       = rsp_valid_r;
  assign rsp.top_cell    = rsp_top_r;
  assign rsp.stack_depth = rsp_depth_r;
  assign rsp.error_code  = rsp_err_r;

endmodule
